@@ design/cpu16_next_pc_predictor_defines.svh @@
// ----------------------------------------------------------------------------
// cpu16_next_pc_predictor_defines
// Assertion macros shared by the next-PC predictor RTL.
// ----------------------------------------------------------------------------
`ifndef CPU16_NEXT_PC_PREDICTOR_DEFINES_SVH
`define CPU16_NEXT_PC_PREDICTOR_DEFINES_SVH

// check a property on every rising clk edge outside reset
`define NPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a property on the next clk edge
`define NPC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ design/cpu16_npc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpu16_npc_pkg
// Types, opcode constants and the base length table of the next-PC predictor.
// ----------------------------------------------------------------------------
package cpu16_npc_pkg;

	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic [7:0] OP_BRA = 8'h80;
	localparam logic [7:0] OP_BRL = 8'h82;
	localparam logic [7:0] OP_JMP_ABS = 8'h4C;
	localparam logic [7:0] OP_JSL = 8'h22;
	localparam logic [7:0] OP_JML = 8'h5C;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_CPY_IMM = 8'hC0;
	localparam logic [7:0] OP_CPX_IMM = 8'hE0;
	// low five opcode bits of the conditional branches and accumulator immediates
	localparam logic [4:0] BCC_LOW = 5'h10;
	localparam logic [4:0] ACC_IMM_LOW = 5'h09;
	localparam int unsigned FLAG_M = 5;
	localparam int unsigned FLAG_X = 4;

	typedef struct packed {
		logic [23:0] pc_long;
		logic [7:0]  opcode;
		logic [7:0]  operand_lo;
		logic [7:0]  operand_hi;
		logic [7:0]  operand_bank;
		logic [7:0]  status_flags;
	} npc_item_t;

	typedef struct packed {
		logic [23:0] next_address;
		logic [23:0] alt_address;
		logic        has_alt;
		logic [2:0]  insn_length;
	} npc_result_t;

	// native-mode base size, 8-bit immediates
	localparam logic [2:0] BASE_LEN [256] = '{
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd3,3'd2,3'd4,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd1,3'd2,3'd2,3'd2, 3'd3,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd3,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd4,3'd3,3'd3,3'd4,
		3'd1,3'd2,3'd3,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd3,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd2,3'd2,3'd2,3'd2, 3'd1,3'd2,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2, 3'd3,3'd2,3'd2,3'd2, 3'd1,3'd3,3'd1,3'd1, 3'd3,3'd3,3'd3,3'd4
	};

endpackage

@@ design/cpu16_npc_decode.sv @@
// ----------------------------------------------------------------------------
// cpu16_npc_decode
// Length decode and next / branch target address generation for one opcode.
// ----------------------------------------------------------------------------
module cpu16_npc_decode import cpu16_npc_pkg::*; (
	input  npc_item_t   item,
	output npc_result_t result
);

	logic [7:0]  bank;
	logic [15:0] pc16;
	logic [2:0]  len;
	logic        acc_imm;
	logic        idx_imm;
	logic [15:0] fall_pc;
	logic [15:0] rel8_pc;
	logic [15:0] rel16_pc;
	logic [23:0] fall_addr;
	logic [23:0] rel8_addr;

	assign bank = item.pc_long[23:16];
	assign pc16 = item.pc_long[15:0];

	assign acc_imm = (item.opcode[4:0] == ACC_IMM_LOW) && !item.status_flags[FLAG_M];
	assign idx_imm = ((item.opcode == OP_LDY_IMM) || (item.opcode == OP_LDX_IMM) ||
		(item.opcode == OP_CPY_IMM) || (item.opcode == OP_CPX_IMM)) &&
		!item.status_flags[FLAG_X];

	assign len = BASE_LEN[item.opcode] + {2'b00, acc_imm} + {2'b00, idx_imm};

	// all PC arithmetic wraps inside the bank
	assign fall_pc  = pc16 + {13'd0, len};
	assign rel8_pc  = pc16 + 16'd2 + {{8{item.operand_lo[7]}}, item.operand_lo};
	assign rel16_pc = pc16 + 16'd3 + {item.operand_hi, item.operand_lo};

	assign fall_addr = {bank, fall_pc};
	assign rel8_addr = {bank, rel8_pc};

	always_comb begin
		result.next_address = fall_addr;
		result.alt_address  = 24'd0;
		result.has_alt      = 1'b0;
		result.insn_length  = len;
		if (item.opcode[4:0] == BCC_LOW) begin
			// a taken target equal to the fall-through is not reported
			if (rel8_addr != fall_addr) begin
				result.alt_address = rel8_addr;
				result.has_alt     = 1'b1;
			end
		end else begin
			case (item.opcode)
				OP_BRA: begin
					result.next_address = rel8_addr;
				end
				OP_BRL: begin
					result.next_address = {bank, rel16_pc};
				end
				OP_JMP_ABS: begin
					result.next_address = {bank, item.operand_hi, item.operand_lo};
				end
				OP_JSL, OP_JML: begin
					result.next_address = {item.operand_bank, item.operand_hi, item.operand_lo};
				end
				default: begin
					result.next_address = fall_addr;
				end
			endcase
		end
	end

endmodule

@@ design/cpu16_next_pc_predictor.sv @@
// ----------------------------------------------------------------------------
// cpu16_next_pc_predictor
// Native-mode instruction length and next program address predictor.
// ----------------------------------------------------------------------------
// Takes one fetch transaction per clock when not back-pressured and returns one
// result transaction per fetch, in order, via the input and result registers.
// The fetch is captured in an input register, decoded by one short layer of
// logic (table lookup, three 16-bit adds, a compare) and held in a result
// register; while a result waits the input keeps accepting as long as the
// input register is free or moving; unstalled, one transaction per cycle.
// Input tdata, low bit first: pc_long[23:0], opcode, operand_lo, operand_hi,
// operand_bank, status_flags. Output tdata, low bit first: next_address[23:0],
// alt_address[23:0], has_alt, insn_length[2:0], four zero pad bits.
`include "cpu16_next_pc_predictor_defines.svh"

module cpu16_next_pc_predictor import cpu16_npc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pc_long, opcode, operand_lo, operand_hi, operand_bank, status_flags
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// next_address, alt_address, has_alt, insn_length, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	npc_item_t   in_item;
	npc_item_t   item_s1;
	npc_result_t result;
	npc_result_t result_s2;
	logic        valid_s1;
	logic        valid_s2;
	logic        adv_s2;

	assign in_item.pc_long      = s_axis_tdata[23:0];
	assign in_item.opcode       = s_axis_tdata[31:24];
	assign in_item.operand_lo   = s_axis_tdata[39:32];
	assign in_item.operand_hi   = s_axis_tdata[47:40];
	assign in_item.operand_bank = s_axis_tdata[55:48];
	assign in_item.status_flags = s_axis_tdata[63:56];

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item;
		end
		if (valid_s1 && adv_s2) begin
			result_s2 <= result;
		end
	end

	cpu16_npc_decode u_decode (
		.item   (item_s1),
		.result (result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, result_s2.insn_length, result_s2.has_alt,
		result_s2.alt_address, result_s2.next_address};

	`NPC_ASSERT(a_alt_distinct, m_axis_tvalid && result_s2.has_alt |->
		result_s2.alt_address != result_s2.next_address, "alt target equals fall-through")
	`NPC_ASSERT(a_alt_zero, m_axis_tvalid && !result_s2.has_alt |->
		result_s2.alt_address == 24'd0, "alt address nonzero without branch")
	`NPC_ASSERT(a_len_range, m_axis_tvalid |->
		result_s2.insn_length != 3'd0 && result_s2.insn_length <= 3'd4, "bad length")
	`NPC_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s2, valid_s1 && $stable(item_s1),
		"input stage lost while output stalled")

endmodule
